// ===== hw/rtl/tct_pkg.sv =====
// Package for the TCP connection tracker: constants, event codes and payload types.
// Used by the channel interfaces and all tracker modules.
`default_nettype none
package tct_pkg;
    localparam int EST_SLOTS_DEF = 5;
    localparam int PENDING_SLOTS_DEF = 16;
    localparam logic [31:0] LOCAL_ADDRESS_RESET = 32'hC0A80106;

    typedef enum logic [2:0] {
        EV_NONE = 3'd0,
        EV_SYN_TRACKED = 3'd1,
        EV_PEND_FULL = 3'd2,
        EV_ESTABLISHED = 3'd3,
        EV_DISCARDED = 3'd4,
        EV_FIN_CLOSED = 3'd5,
        EV_RST_CLOSED = 3'd6
    } event_t;

    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic        flag_syn;
        logic        flag_ack;
        logic        flag_fin;
        logic        flag_rst;
        logic [31:0] sequence_number;
        logic [31:0] ack_number;
    } header_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [4:0] slot;
        logic [5:0] active_count;
    } result_t;
endpackage
`default_nettype wire

// ===== hw/rtl/tct_header_if.sv =====
// Valid/ready channel interfaces for header requests and result requests.
// Depends on tct_pkg.
`default_nettype none
interface tct_header_if;
    logic              valid;
    logic              ready;
    tct_pkg::header_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tct_result_if;
    logic              valid;
    logic              ready;
    tct_pkg::result_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tct_tables.sv =====
// Pending and established tables with combinational lookup and registered update logic.
// Depends on tct_pkg.
`default_nettype none
module tct_tables #(
    parameter int EST_SLOTS = 5,
    parameter int PENDING_SLOTS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             hdr_valid,
    input  tct_pkg::header_t      hdr,
    input  wire logic [31:0]      local_address,
    output tct_pkg::result_t      result
);
    import tct_pkg::*;

    localparam int EW = (EST_SLOTS > 1) ? $clog2(EST_SLOTS) : 1;
    localparam int PW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;

    logic [EST_SLOTS-1:0]     est_valid_reg, est_valid_next;
    logic [63:0]              est_addr_reg [EST_SLOTS];
    logic [31:0]              est_port_reg [EST_SLOTS];
    logic [2:0]               est_phase_reg [EST_SLOTS];
    logic [31:0]              est_seq_reg [EST_SLOTS];
    logic [PENDING_SLOTS-1:0] pend_valid_reg, pend_valid_next;
    logic [63:0]              pend_addr_reg [PENDING_SLOTS];
    logic [31:0]              pend_port_reg [PENDING_SLOTS];
    logic                     pend_phase_reg [PENDING_SLOTS];
    logic [31:0]              pend_seq_reg [PENDING_SLOTS];

    logic [63:0] fa, ra;
    logic [31:0] fpt, rpt;
    logic [EST_SLOTS-1:0] est_hit_v, est_free_v;
    logic [PENDING_SLOTS-1:0] pend_hit_v, pend_free_v;
    logic est_hit, est_free, pend_hit, pend_free;
    logic [EW-1:0] est_idx, est_free_idx;
    logic [PW-1:0] pend_idx, pend_free_idx;
    logic [31:0] e_seq, p_seq;
    logic [2:0] e_phase;
    logic e_acked, p_acked, finack, fwd;

    // Write controls.
    logic pend_wr_new, pend_set_phase, pend_wr_seq, pend_clr;
    logic [PW-1:0] pend_wr_idx;
    logic est_wr_seq, est_wr_phase, est_clr, est_new;
    logic [2:0] est_phase_new;
    logic [2:0] ev;
    logic [4:0] slot_v;

    assign fa  = {hdr.source_address, hdr.dest_address};
    assign ra  = {hdr.dest_address, hdr.source_address};
    assign fpt = {hdr.source_port, hdr.dest_port};
    assign rpt = {hdr.dest_port, hdr.source_port};

    always_comb
    begin
        for (int i = 0; i < EST_SLOTS; i++)
        begin
            est_hit_v[i] = est_valid_reg[i] &&
                ((est_addr_reg[i] == fa && est_port_reg[i] == fpt) ||
                 (est_addr_reg[i] == ra && est_port_reg[i] == rpt));
            est_free_v[i] = !est_valid_reg[i];
        end
        for (int i = 0; i < PENDING_SLOTS; i++)
        begin
            pend_hit_v[i] = pend_valid_reg[i] &&
                ((pend_addr_reg[i] == fa && pend_port_reg[i] == fpt) ||
                 (pend_addr_reg[i] == ra && pend_port_reg[i] == rpt));
            pend_free_v[i] = !pend_valid_reg[i];
        end
    end

    always_comb
    begin
        est_idx = '0;
        est_free_idx = '0;
        for (int i = EST_SLOTS - 1; i >= 0; i--)
        begin
            if (est_hit_v[i])
            begin
                est_idx = EW'(i);
            end
            if (est_free_v[i])
            begin
                est_free_idx = EW'(i);
            end
        end
        pend_idx = '0;
        pend_free_idx = '0;
        for (int i = PENDING_SLOTS - 1; i >= 0; i--)
        begin
            if (pend_hit_v[i])
            begin
                pend_idx = PW'(i);
            end
            if (pend_free_v[i])
            begin
                pend_free_idx = PW'(i);
            end
        end
    end

    assign est_hit   = |est_hit_v;
    assign est_free  = |est_free_v;
    assign pend_hit  = |pend_hit_v;
    assign pend_free = |pend_free_v;
    assign e_seq     = est_seq_reg[est_idx];
    assign e_phase   = est_phase_reg[est_idx];
    assign p_seq     = pend_seq_reg[pend_idx];
    assign e_acked   = hdr.flag_ack && (hdr.ack_number == e_seq + 32'd1);
    assign p_acked   = hdr.flag_ack && (hdr.ack_number == p_seq + 32'd1);
    assign finack    = hdr.flag_fin && hdr.flag_ack;
    assign fwd       = (est_addr_reg[est_idx][63:32] == hdr.source_address) &&
                       (est_port_reg[est_idx][31:16] == hdr.source_port);

    always_comb
    begin
        ev = EV_NONE;
        slot_v = '0;
        pend_wr_new = 1'b0;
        pend_set_phase = 1'b0;
        pend_wr_seq = 1'b0;
        pend_clr = 1'b0;
        pend_wr_idx = pend_idx;
        est_wr_seq = 1'b0;
        est_wr_phase = 1'b0;
        est_phase_new = e_phase;
        est_clr = 1'b0;
        est_new = 1'b0;
        if (hdr.flag_rst)
        begin
            pend_clr = pend_hit;
            if (est_hit)
            begin
                est_clr = 1'b1;
                ev = EV_RST_CLOSED;
                slot_v = 5'(est_idx);
            end
        end
        else if (hdr.flag_syn && hdr.source_address == local_address)
        begin
            if (pend_hit || pend_free)
            begin
                pend_wr_new = 1'b1;
                pend_wr_idx = pend_hit ? pend_idx : pend_free_idx;
                ev = EV_SYN_TRACKED;
            end
            else
            begin
                ev = EV_PEND_FULL;
            end
        end
        else if (est_hit)
        begin
            est_wr_seq = 1'b1;
            case (e_phase)
                3'd0: if (finack) begin est_wr_phase = 1'b1; est_phase_new = fwd ? 3'd1 : 3'd4; end
                3'd1: if (e_acked) begin est_wr_phase = 1'b1; est_phase_new = 3'd2; end
                3'd2: if (finack) begin est_wr_phase = 1'b1; est_phase_new = 3'd3; end
                3'd4: if (e_acked) begin est_wr_phase = 1'b1; est_phase_new = 3'd5; end
                3'd5: if (finack) begin est_wr_phase = 1'b1; est_phase_new = 3'd6; end
                3'd3, 3'd6:
                    if (e_acked)
                    begin
                        est_clr = 1'b1;
                        ev = EV_FIN_CLOSED;
                        slot_v = 5'(est_idx);
                    end
                default: ;
            endcase
        end
        else if (pend_hit)
        begin
            if (!pend_phase_reg[pend_idx])
            begin
                pend_wr_seq = 1'b1;
                pend_set_phase = hdr.flag_syn && p_acked;
            end
            else if (p_acked)
            begin
                pend_clr = 1'b1;
                if (est_free)
                begin
                    est_new = 1'b1;
                    ev = EV_ESTABLISHED;
                    slot_v = 5'(est_free_idx);
                end
                else
                begin
                    ev = EV_DISCARDED;
                end
            end
            else
            begin
                pend_wr_seq = 1'b1;
            end
        end
    end

    always_comb
    begin
        est_valid_next = est_valid_reg;
        pend_valid_next = pend_valid_reg;
        if (hdr_valid)
        begin
            if (est_clr)
            begin
                est_valid_next[est_idx] = 1'b0;
            end
            if (est_new)
            begin
                est_valid_next[est_free_idx] = 1'b1;
            end
            if (pend_clr)
            begin
                pend_valid_next[pend_idx] = 1'b0;
            end
            if (pend_wr_new)
            begin
                pend_valid_next[pend_wr_idx] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_valid_reg <= '0;
            pend_valid_reg <= '0;
        end
        else
        begin
            est_valid_reg <= est_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_valid)
        begin
            if (pend_wr_new)
            begin
                pend_addr_reg[pend_wr_idx] <= fa;
                pend_port_reg[pend_wr_idx] <= fpt;
                pend_phase_reg[pend_wr_idx] <= 1'b0;
                pend_seq_reg[pend_wr_idx] <= hdr.sequence_number;
            end
            if (pend_wr_seq)
            begin
                pend_seq_reg[pend_idx] <= hdr.sequence_number;
            end
            if (pend_set_phase)
            begin
                pend_phase_reg[pend_idx] <= 1'b1;
            end
            if (est_wr_seq)
            begin
                est_seq_reg[est_idx] <= hdr.sequence_number;
            end
            if (est_wr_phase)
            begin
                est_phase_reg[est_idx] <= est_phase_new;
            end
            if (est_new)
            begin
                est_addr_reg[est_free_idx] <= pend_addr_reg[pend_idx];
                est_port_reg[est_free_idx] <= pend_port_reg[pend_idx];
                est_phase_reg[est_free_idx] <= 3'd0;
                est_seq_reg[est_free_idx] <= hdr.sequence_number;
            end
        end
    end

    assign result.event_res = ev;
    assign result.slot = slot_v;
    assign result.active_count = 6'($countones(est_valid_next));

    assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_valid && est_new) |=> est_valid_reg[$past(est_free_idx)])
        else $error("new established slot not set");
    assert property (@(posedge clk) disable iff (!rst_n)
        !hdr_valid |=> est_valid_reg == $past(est_valid_reg))
        else $error("established table changed without a request");
    assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_valid && pend_wr_new) |=> pend_valid_reg[$past(pend_wr_idx)])
        else $error("pending entry not opened");
endmodule
`default_nettype wire

// ===== hw/rtl/tcp_connection_tracker.sv =====
// Top level of the TCP connection tracker: input register, tables, result register.
// Depends on tct_pkg, tct_header_if, tct_result_if and tct_tables.
//
// Usage: parsed TCP header requests enter on hdr_in, one result request per header
// leaves on res_out. Both channels use valid/ready; a request moves when both are high.
// The user must write the local address register through cfg_we/cfg_data only while
// the block is idle; the block itself does not enforce this. A header in the input
// register is looked up and applied to the tables as it advances, and its result is
// registered. Throughput is one header per cycle while res_out.ready stays high.
// The input register takes a new header whenever it is empty or drains this cycle;
// the result register drains when res_out.ready is high. When the receiver stalls,
// the result register holds, then the input register holds, and hdr_in.ready drops.
// Reset clears all valid bits of both tables and sets the local address to its
// default value; no clearing pass is needed.
`default_nettype none
module tcp_connection_tracker #(
    parameter int EST_SLOTS = tct_pkg::EST_SLOTS_DEF,
    parameter int PENDING_SLOTS = tct_pkg::PENDING_SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    tct_header_if.sink       hdr_in,
    tct_result_if.source     res_out,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data
);
    import tct_pkg::*;

    logic [31:0] local_address_reg;
    logic        in_valid_reg;
    header_t     in_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     res_next;
    logic        advance;

    assign advance = in_valid_reg && (!out_valid_reg || res_out.ready);
    assign hdr_in.ready = !in_valid_reg || advance;

    tct_tables #(.EST_SLOTS(EST_SLOTS), .PENDING_SLOTS(PENDING_SLOTS)) u_tables (
        .clk(clk),
        .rst_n(rst_n),
        .hdr_valid(advance),
        .hdr(in_reg),
        .local_address(local_address_reg),
        .result(res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= LOCAL_ADDRESS_RESET;
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                local_address_reg <= cfg_data;
            end
            if (hdr_in.ready)
            begin
                in_valid_reg <= hdr_in.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_in.ready && hdr_in.valid)
        begin
            in_reg <= hdr_in.data;
        end
        if (advance)
        begin
            out_reg <= res_next;
        end
    end

    assign res_out.valid = out_valid_reg;
    assign res_out.data = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_out.ready) |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending header dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.event_res <= 3'd6)
        else $error("bad event code");
endmodule
`default_nettype wire
